FILE: src/ascon128_aead_engine_unit_assert.svh
// Assertion macros used by the checker module of the engine.
// Needs nothing else; included by bare file name.
`ifndef ASCON128_AEAD_ENGINE_UNIT_ASSERT_SVH
`define ASCON128_AEAD_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define AEU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aeu assertion failed");

// next-cycle implication
`define AEU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aeu assertion failed");

`endif

FILE: src/aeu_pkg.sv
// Types, constants, microcode program and round function of the Ascon-128 engine.
// No dependencies; imported by ascon128_aead_engine_unit.
package aeu_pkg;

   typedef logic [4:0][63:0] sponge_type;

   localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;

   localparam logic [2:0] REG_KEY_UPPER   = 3'd0;
   localparam logic [2:0] REG_KEY_LOWER   = 3'd1;
   localparam logic [2:0] REG_NONCE_UPPER = 3'd2;
   localparam logic [2:0] REG_NONCE_LOWER = 3'd3;
   localparam logic [2:0] REG_DECRYPT     = 3'd4;
   localparam logic [2:0] REG_EXP_UPPER   = 3'd5;
   localparam logic [2:0] REG_EXP_LOWER   = 3'd6;

   typedef enum logic [1:0] {
      PH_IDLE, PH_FRESH, PH_ADATA, PH_TEXT
   } phase_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_INIT, OP_PERM12, OP_PERM6, OP_KEY34, OP_KEY12, OP_ABS_FULL,
      OP_ABS_PAD, OP_DSEP, OP_DUPLEX, OP_PAD, OP_CLRN, OP_EMIT, OP_FINISH
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER, C_ALWAYS, C_NOT_FIRST, C_IDLE, C_TEXT_ITEM, C_PH_TEXT, C_LAST,
      C_EMPTY_FRESH, C_N_NOT_FULL
   } cond_type;

   typedef struct packed {
      op_type    op;
      cond_type  cond;
      logic [5:0] target;
      logic      set_phase;
      phase_type phase;
   } uword_type;

   localparam logic [5:0] PC_FINISH = 6'd32;
   localparam logic [5:0] PC_TEXT   = 6'd17;

   function automatic uword_type uw(op_type op, cond_type cond, logic [5:0] target,
                                    logic set_phase, phase_type phase);
      uword_type w;
      w.op        = op;
      w.cond      = cond;
      w.target    = target;
      w.set_phase = set_phase;
      w.phase     = phase;
      return w;
   endfunction

   function automatic uword_type ucode_rom(logic [5:0] pc);
      uword_type w;
      unique case (pc)
         // message start
         6'd0:  w = uw(OP_NOP,      C_NOT_FIRST,   6'd4,      1'b0, PH_IDLE);
         6'd1:  w = uw(OP_INIT,     C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd2:  w = uw(OP_PERM12,   C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd3:  w = uw(OP_KEY34,    C_NEVER,       6'd0,      1'b1, PH_FRESH);
         6'd4:  w = uw(OP_NOP,      C_IDLE,        PC_FINISH, 1'b0, PH_IDLE);
         6'd5:  w = uw(OP_NOP,      C_TEXT_ITEM,   PC_TEXT,   1'b0, PH_IDLE);
         // associated data
         6'd6:  w = uw(OP_NOP,      C_PH_TEXT,     PC_FINISH, 1'b0, PH_IDLE);
         6'd7:  w = uw(OP_NOP,      C_LAST,        6'd10,     1'b0, PH_IDLE);
         6'd8:  w = uw(OP_ABS_FULL, C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd9:  w = uw(OP_PERM6,    C_ALWAYS,      PC_FINISH, 1'b1, PH_ADATA);
         6'd10: w = uw(OP_NOP,      C_EMPTY_FRESH, 6'd16,     1'b0, PH_IDLE);
         6'd11: w = uw(OP_NOP,      C_N_NOT_FULL,  6'd14,     1'b0, PH_IDLE);
         6'd12: w = uw(OP_ABS_FULL, C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd13: w = uw(OP_PERM6,    C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd14: w = uw(OP_ABS_PAD,  C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd15: w = uw(OP_PERM6,    C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd16: w = uw(OP_DSEP,     C_ALWAYS,      PC_FINISH, 1'b1, PH_TEXT);
         // text
         6'd17: w = uw(OP_NOP,      C_PH_TEXT,     6'd19,     1'b0, PH_IDLE);
         6'd18: w = uw(OP_DSEP,     C_NEVER,       6'd0,      1'b1, PH_TEXT);
         6'd19: w = uw(OP_NOP,      C_LAST,        6'd23,     1'b0, PH_IDLE);
         6'd20: w = uw(OP_DUPLEX,   C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd21: w = uw(OP_PERM6,    C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd22: w = uw(OP_EMIT,     C_NEVER,       6'd0,      1'b0, PH_IDLE);
         // final text block and finalization
         6'd23: w = uw(OP_DUPLEX,   C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd24: w = uw(OP_NOP,      C_N_NOT_FULL,  6'd27,     1'b0, PH_IDLE);
         6'd25: w = uw(OP_PERM6,    C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd26: w = uw(OP_CLRN,     C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd27: w = uw(OP_PAD,      C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd28: w = uw(OP_KEY12,    C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd29: w = uw(OP_PERM12,   C_NEVER,       6'd0,      1'b0, PH_IDLE);
         6'd30: w = uw(OP_KEY34,    C_NEVER,       6'd0,      1'b1, PH_IDLE);
         6'd31: w = uw(OP_EMIT,     C_NEVER,       6'd0,      1'b0, PH_IDLE);
         default: w = uw(OP_FINISH, C_NEVER,       6'd0,      1'b0, PH_IDLE);
      endcase
      return w;
   endfunction

   // top n bytes set; n of eight or more gives all ones
   function automatic logic [63:0] top_mask(logic [3:0] n);
      logic [63:0] m;
      if (n[3]) begin
         m = '1;
      end else begin
         m = ~({64{1'b1}} >> {n[2:0], 3'b000});
      end
      return m;
   endfunction

   function automatic logic [63:0] pad_word(logic [2:0] n);
      return 64'h8000_0000_0000_0000 >> {n, 3'b000};
   endfunction

   function automatic sponge_type ascon_round(sponge_type s, logic [3:0] idx);
      logic [63:0] x0, x1, x2, x3, x4;
      logic [63:0] t0, t1, t2, t3, t4;
      logic [7:0]  c;
      sponge_type  r;
      c  = {4'hf - idx, idx};
      x0 = s[0]; x1 = s[1]; x2 = s[2] ^ {56'd0, c}; x3 = s[3]; x4 = s[4];
      x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
      t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
      x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
      x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
      r[0] = x0 ^ {x0[18:0], x0[63:19]} ^ {x0[27:0], x0[63:28]};
      r[1] = x1 ^ {x1[60:0], x1[63:61]} ^ {x1[38:0], x1[63:39]};
      r[2] = x2 ^ {x2[0],    x2[63:1]}  ^ {x2[5:0],  x2[63:6]};
      r[3] = x3 ^ {x3[9:0],  x3[63:10]} ^ {x3[16:0], x3[63:17]};
      r[4] = x4 ^ {x4[6:0],  x4[63:7]}  ^ {x4[40:0], x4[63:41]};
      return r;
   endfunction

endpackage

FILE: src/ascon128_aead_engine_unit.sv
// Ascon-128 AEAD engine: microcoded sequencer over a one-round-per-cycle datapath.
// Depends on aeu_pkg (types, microcode table, round function).
//
// Usage: program key, nonce, decrypt and expected tag through the csr_ APB port
// (64-bit registers at byte addresses 0,8,..,48) while the engine is idle. Stream
// 64-bit blocks on req_: tuser[1] starts a message, tuser[0] picks associated data
// (0) or text (1), tlast marks the final block of that kind, tdata[67:64] holds the
// byte count. Each text block gives one rsp_ transaction; the final one has tlast
// set and carries the tag and, when decrypting, the match flag in tuser.
// Timing: one sequencer step per cycle unless an emit step stalls, permutation rounds
// one per cycle. A new block is accepted only after the engine is through with the
// last one. A first block adds load, 12 rounds and key add; the first text block of
// a message without associated data adds a domain separation step. A full final text
// block adds an extra 6-round pass before finalization, as does a full final
// associated-data block before its padded absorb.
// req_tready is high only while the sequencer is idle.
// Results sit in an output register; a new block is accepted while one waits. If
// rsp_tready is low when the next result is due, the sequencer holds at that step.
// Reset (synchronous) clears the configuration registers, the sequencer state, the message phase and the output valid.
module ascon128_aead_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,    // block[63:0], byte_count[67:64], zero[71:68]
   input  logic [1:0]  req_tuser,    // mode[0], first[1]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // text_out[63:0], out_bytes[67:64], tag_upper[131:68], tag_lower[195:132], zero
   output logic [199:0] rsp_tdata,
   output logic [0:0]  rsp_tuser,    // tag_ok[0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import aeu_pkg::*;

   logic [63:0] key_upper_ff, key_lower_ff, nonce_upper_ff, nonce_lower_ff;
   logic [63:0] exp_upper_ff, exp_lower_ff;
   logic        decrypt_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   logic        busy_ff, busy_in;
   logic [5:0]  pc_ff, pc_in;
   logic        in_perm_ff, in_perm_in;
   logic [3:0]  rnd_ff, rnd_in;
   phase_type   phase_ff, phase_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        mode_ff, first_ff, last_ff;
   logic [63:0] blk_ff;
   logic [3:0]  n_ff;
   sponge_type  s_ff;
   logic [63:0] tout_ff;
   logic [3:0]  obytes_ff;
   logic [63:0] rsp_text_ff, rsp_tagu_ff, rsp_tagl_ff;
   logic [3:0]  rsp_bytes_ff;
   logic        rsp_done_ff, rsp_ok_ff;

   uword_type   w;
   logic        accept, is_perm, perm_last, emit_stall, step_done, cond_true, emit_fire;
   logic [3:0]  cur_idx, n_sat;
   logic [63:0] dmask, ddata, dout, dx0;
   sponge_type  s_round;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff   <= '0;
         key_lower_ff   <= '0;
         nonce_upper_ff <= '0;
         nonce_lower_ff <= '0;
         decrypt_ff     <= 1'b0;
         exp_upper_ff   <= '0;
         exp_lower_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_KEY_UPPER:   key_upper_ff   <= csr_pwdata;
            REG_KEY_LOWER:   key_lower_ff   <= csr_pwdata;
            REG_NONCE_UPPER: nonce_upper_ff <= csr_pwdata;
            REG_NONCE_LOWER: nonce_lower_ff <= csr_pwdata;
            REG_DECRYPT:     decrypt_ff     <= csr_pwdata[0];
            REG_EXP_UPPER:   exp_upper_ff   <= csr_pwdata;
            REG_EXP_LOWER:   exp_lower_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_KEY_UPPER:   csr_prdata = key_upper_ff;
         REG_KEY_LOWER:   csr_prdata = key_lower_ff;
         REG_NONCE_UPPER: csr_prdata = nonce_upper_ff;
         REG_NONCE_LOWER: csr_prdata = nonce_lower_ff;
         REG_DECRYPT:     csr_prdata = {63'd0, decrypt_ff};
         REG_EXP_UPPER:   csr_prdata = exp_upper_ff;
         REG_EXP_LOWER:   csr_prdata = exp_lower_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // sequencer
   assign req_tready = ~busy_ff;
   assign accept     = req_tvalid & req_tready;
   assign w          = ucode_rom(pc_ff);
   assign is_perm    = (w.op == OP_PERM6) || (w.op == OP_PERM12);
   assign cur_idx    = in_perm_ff ? rnd_ff : ((w.op == OP_PERM12) ? 4'd0 : 4'd6);
   assign perm_last  = (cur_idx == 4'd11);
   assign emit_stall = (w.op == OP_EMIT) && rsp_valid_ff && !rsp_tready;
   assign step_done  = busy_ff && (!is_perm || perm_last) && !emit_stall;
   assign emit_fire  = busy_ff && (w.op == OP_EMIT) && !emit_stall;
   assign n_sat      = (!req_tlast || req_tdata[67:64] > 4'd8) ? 4'd8 : req_tdata[67:64];

   always_comb begin
      case (w.cond)
         C_ALWAYS:      cond_true = 1'b1;
         C_NOT_FIRST:   cond_true = !first_ff;
         C_IDLE:        cond_true = (phase_ff == PH_IDLE);
         C_TEXT_ITEM:   cond_true = mode_ff;
         C_PH_TEXT:     cond_true = (phase_ff == PH_TEXT);
         C_LAST:        cond_true = last_ff;
         C_EMPTY_FRESH: cond_true = (phase_ff == PH_FRESH) && (n_ff == 4'd0);
         C_N_NOT_FULL:  cond_true = !n_ff[3];
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      in_perm_in   = in_perm_ff;
      rnd_in       = rnd_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (busy_ff) begin
         if (is_perm) begin
            in_perm_in = !perm_last;
            rnd_in     = cur_idx + 4'd1;
         end
         if (step_done) begin
            if (w.set_phase) begin
               phase_in = w.phase;
            end
            if (w.op == OP_EMIT || w.op == OP_FINISH) begin
               busy_in = 1'b0;
            end else begin
               pc_in = cond_true ? w.target : pc_ff + 6'd1;
            end
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         in_perm_ff   <= 1'b0;
         rnd_ff       <= '0;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         in_perm_ff   <= in_perm_in;
         rnd_ff       <= rnd_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   assign s_round = ascon_round(s_ff, cur_idx);
   assign dmask   = top_mask(n_ff);
   assign ddata   = blk_ff & dmask;

   always_comb begin
      if (decrypt_ff) begin
         dout = (s_ff[0] ^ ddata) & dmask;
         dx0  = (s_ff[0] & ~dmask) | ddata;
      end else begin
         dx0  = s_ff[0] ^ ddata;
         dout = dx0 & dmask;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_tuser[0];
         first_ff <= req_tuser[1];
         last_ff  <= req_tlast;
         blk_ff   <= req_tdata[63:0];
         n_ff     <= n_sat;
      end else if (busy_ff) begin
         case (w.op)
            OP_INIT: begin
               s_ff[0] <= ASCON_IV;
               s_ff[1] <= key_upper_ff;
               s_ff[2] <= key_lower_ff;
               s_ff[3] <= nonce_upper_ff;
               s_ff[4] <= nonce_lower_ff;
            end
            OP_PERM6, OP_PERM12: s_ff <= s_round;
            OP_KEY34: begin
               s_ff[3] <= s_ff[3] ^ key_upper_ff;
               s_ff[4] <= s_ff[4] ^ key_lower_ff;
            end
            OP_KEY12: begin
               s_ff[1] <= s_ff[1] ^ key_upper_ff;
               s_ff[2] <= s_ff[2] ^ key_lower_ff;
            end
            OP_ABS_FULL: begin
               s_ff[0] <= s_ff[0] ^ blk_ff;
               n_ff    <= 4'd0;
            end
            OP_ABS_PAD: s_ff[0] <= s_ff[0] ^ ddata ^ pad_word(n_ff[2:0]);
            OP_DSEP:    s_ff[4] <= s_ff[4] ^ 64'd1;
            OP_DUPLEX: begin
               s_ff[0]   <= dx0;
               tout_ff   <= dout;
               obytes_ff <= n_ff;
            end
            OP_PAD:  s_ff[0] <= s_ff[0] ^ pad_word(n_ff[2:0]);
            OP_CLRN: n_ff    <= 4'd0;
            default: ;
         endcase
      end
      if (emit_fire) begin
         rsp_text_ff  <= tout_ff;
         rsp_bytes_ff <= last_ff ? obytes_ff : 4'd8;
         rsp_done_ff  <= last_ff;
         rsp_tagu_ff  <= last_ff ? s_ff[3] : 64'd0;
         rsp_tagl_ff  <= last_ff ? s_ff[4] : 64'd0;
         rsp_ok_ff    <= last_ff && decrypt_ff && (s_ff[3] == exp_upper_ff)
                         && (s_ff[4] == exp_lower_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_tagl_ff, rsp_tagu_ff, rsp_bytes_ff, rsp_text_ff};
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

FILE: src/aeu_checker.sv
// Port-level checker for ascon128_aead_engine_unit, bound to the top level.
// Depends on ascon128_aead_engine_unit_assert.svh for the assertion macros.
`include "ascon128_aead_engine_unit_assert.svh"

module aeu_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [71:0]  req_tdata,
   input logic [1:0]   req_tuser,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata,
   input logic [0:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic         csr_psel,
   input logic         csr_penable,
   input logic         csr_pwrite,
   input logic [5:0]   csr_paddr,
   input logic [63:0]  csr_pwdata,
   input logic [63:0]  csr_prdata,
   input logic         csr_pready
);

   // stalled result holds
   `AEU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // engine is busy right after taking a block
   `AEU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // tag and match flag only on the final text block
   `AEU_ASSERT_IMPL(a_tag_only_final, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[195:68] == 128'd0 && rsp_tuser == 1'b0)
   // middle text blocks are always full
   `AEU_ASSERT_IMPL(a_mid_full, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[67:64] == 4'd8)

endmodule

bind ascon128_aead_engine_unit aeu_checker u_aeu_checker (.*);
